FILE: sv/fjop_pkg.sv
// Shared types, constants and helper functions for the flat JSON object parser.
`default_nettype none

package fjop_pkg;

  // Default depth of the result queue (power of two, at least 2)
  localparam int unsigned FJOP_QDEPTH = 4;

  // Grammar bytes
  localparam logic [7:0] CH_LBRACE    = 8'h7B;  // '{'
  localparam logic [7:0] CH_RBRACE    = 8'h7D;  // '}'
  localparam logic [7:0] CH_COLON     = 8'h3A;  // ':'
  localparam logic [7:0] CH_COMMA     = 8'h2C;  // ','
  localparam logic [7:0] CH_QUOTE     = 8'h22;  // '"'
  localparam logic [7:0] CH_BSLASH    = 8'h5C;  // '\'
  localparam logic [7:0] CH_SLASH     = 8'h2F;  // '/'
  localparam logic [7:0] CH_N         = 8'h6E;  // 'n'
  localparam logic [7:0] CH_R         = 8'h72;  // 'r'
  localparam logic [7:0] CH_T         = 8'h74;  // 't'
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // Parser phase
  typedef enum logic [3:0] {
    PH_OPEN         = 4'd0,
    PH_KEY_OR_CLOSE = 4'd1,
    PH_KEY          = 4'd2,
    PH_KEY_ESC      = 4'd3,
    PH_COLON        = 4'd4,
    PH_VAL_QUOTE    = 4'd5,
    PH_VAL          = 4'd6,
    PH_VAL_ESC      = 4'd7,
    PH_AFTER_PAIR   = 4'd8,
    PH_DONE         = 4'd9,
    PH_ERROR        = 4'd10
  } phase_t;

  // Result kind
  typedef enum logic [2:0] {
    K_KEY_CHAR = 3'd0,
    K_KEY_END  = 3'd1,
    K_VAL_CHAR = 3'd2,
    K_PAIR_END = 3'd3,
    K_DONE     = 3'd4,
    K_ERROR    = 3'd5
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } res_t;

  // Decoder outcome for one byte
  typedef struct packed {
    phase_t     nxt;
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } dec_t;

  // Whitespace outside strings: 9..13 and space
  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  // Escape letter decode: {accepted, character}
  function automatic logic [8:0] esc_decode(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: r = {1'b1, b};
      CH_N:    r = {1'b1, CH_LF};
      CH_R:    r = {1'b1, CH_CR};
      CH_T:    r = {1'b1, CH_TAB};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fjop_decode.sv
// Per-byte phase transition and result generation of the parser.
`default_nettype none

module fjop_decode (
  input  fjop_pkg::phase_t phase,
  input  logic [7:0]       in_byte,
  input  logic             msg_last,
  output fjop_pkg::dec_t   dec
);
  import fjop_pkg::*;

  phase_t     ph_mid;
  logic       v0;
  kind_t      k0;
  logic [7:0] c0;
  logic       ws;
  logic [8:0] esc;
  logic       end_err;
  res_t       first_res;
  res_t       err_res;

  assign ws  = is_ws(in_byte);
  assign esc = esc_decode(in_byte);

  // Grammar step for the byte
  always_comb begin
    ph_mid = phase;
    v0     = 1'b0;
    k0     = K_ERROR;
    c0     = 8'd0;
    unique case (phase)
      PH_OPEN: begin
        if (in_byte == CH_LBRACE) ph_mid = PH_KEY_OR_CLOSE;
        else if (!ws) begin
          ph_mid = PH_ERROR; v0 = 1'b1; k0 = K_ERROR;
        end
      end
      PH_KEY_OR_CLOSE, PH_AFTER_PAIR: begin
        if (in_byte == CH_QUOTE) ph_mid = PH_KEY;
        else if (in_byte == CH_RBRACE) begin
          ph_mid = PH_DONE; v0 = 1'b1; k0 = K_DONE;
        end else if (in_byte == CH_COMMA && phase == PH_AFTER_PAIR) begin
          ph_mid = PH_KEY_OR_CLOSE;
        end else if (!ws) begin
          ph_mid = PH_ERROR; v0 = 1'b1; k0 = K_ERROR;
        end
      end
      PH_KEY: begin
        if (in_byte == CH_QUOTE) begin
          ph_mid = PH_COLON; v0 = 1'b1; k0 = K_KEY_END;
        end else if (in_byte == CH_BSLASH) ph_mid = PH_KEY_ESC;
        else begin
          v0 = 1'b1; k0 = K_KEY_CHAR; c0 = in_byte;
        end
      end
      PH_KEY_ESC: begin
        v0 = 1'b1;
        if (esc[8]) begin
          ph_mid = PH_KEY; k0 = K_KEY_CHAR; c0 = esc[7:0];
        end else begin
          ph_mid = PH_ERROR; k0 = K_ERROR;
        end
      end
      PH_COLON: begin
        if (in_byte == CH_COLON) ph_mid = PH_VAL_QUOTE;
        else if (!ws) begin
          ph_mid = PH_ERROR; v0 = 1'b1; k0 = K_ERROR;
        end
      end
      PH_VAL_QUOTE: begin
        if (in_byte == CH_QUOTE) ph_mid = PH_VAL;
        else if (!ws) begin
          ph_mid = PH_ERROR; v0 = 1'b1; k0 = K_ERROR;
        end
      end
      PH_VAL: begin
        if (in_byte == CH_QUOTE) begin
          ph_mid = PH_AFTER_PAIR; v0 = 1'b1; k0 = K_PAIR_END;
        end else if (in_byte == CH_BSLASH) ph_mid = PH_VAL_ESC;
        else begin
          v0 = 1'b1; k0 = K_VAL_CHAR; c0 = in_byte;
        end
      end
      PH_VAL_ESC: begin
        v0 = 1'b1;
        if (esc[8]) begin
          ph_mid = PH_VAL; k0 = K_VAL_CHAR; c0 = esc[7:0];
        end else begin
          ph_mid = PH_ERROR; k0 = K_ERROR;
        end
      end
      default: ;  // done, error: byte ignored
    endcase
  end

  // Message end: truncated object adds an error, phase restarts
  assign end_err = msg_last && (ph_mid != PH_DONE) && (ph_mid != PH_ERROR);

  assign first_res = '{kind: k0, ch: c0, last: !end_err};
  assign err_res   = '{kind: K_ERROR, ch: 8'd0, last: 1'b1};

  always_comb begin
    dec.nxt = msg_last ? PH_OPEN : ph_mid;
    dec.cnt = {1'b0, v0} + {1'b0, end_err};
    dec.r0  = v0 ? first_res : err_res;
    dec.r1  = err_res;
  end

endmodule

`default_nettype wire

FILE: sv/fjop_queue.sv
// Result queue: up to two writes and one read per cycle.
`default_nettype none

module fjop_queue #(
  parameter int unsigned W     = 12,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push0,
  input  logic                       push1,
  input  logic [W-1:0]               wdata0,
  input  logic [W-1:0]               wdata1,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic                       not_empty,
  output logic [$clog2(DEPTH):0]     count
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [W-1:0]  slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [AW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + AW'(1);

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push0) + AW'(push1);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    cnt_nxt    = cnt_r + (AW+1)'(push0) + (AW+1)'(push1) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage slots
  always_ff @(posedge clk) begin
    if (push0) slot_r[wr_ptr_r]  <= wdata0;
    if (push1) slot_r[wr_ptr_p1] <= wdata1;
  end

  assign rdata     = slot_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule

`default_nettype wire

FILE: sv/flat_json_object_parser_top.sv
// Top level of the streaming flat JSON object parser.
`default_nettype none

// Checks a byte stream as a flat JSON object of string keys and string values and
// emits one result per output transfer: decoded key/value characters, key end,
// pair end, object done and error marks (kind on out_tuser, out_tlast on the last
// result of each input byte). Each accepted byte is held in the input
// register, where the phase decoder yields zero, one or two results that are
// written into a QDEPTH-entry result queue. One byte is taken per cycle as long
// as the queue holds at least two free entries; input readiness depends only on
// registered state. Bytes producing two results (a truncated message end) need
// two output transfers, so the output side sets the rate in that case.
// The phase returns to the start after every byte flagged with in_tlast.
module flat_json_object_parser_top #(
  parameter int unsigned QDEPTH = fjop_pkg::FJOP_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // msg_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [2:0] out_tuser,  // [2:0] kind
  output logic       out_tlast   // run_last
);
  import fjop_pkg::*;

  localparam int unsigned CW = $clog2(QDEPTH) + 1;
  localparam int unsigned RW = $bits(res_t);

  logic          stg_vld_r, stg_vld_nxt;
  logic [7:0]    stg_byte_r;
  logic          stg_last_r;
  phase_t        phase_r, phase_nxt;
  dec_t          dec;
  logic          in_xfer;
  logic          advance;
  logic          q_room;
  logic [CW-1:0] q_count;
  logic          q_not_empty;
  logic [RW-1:0] q_rdata;
  res_t          head;
  logic          pop;

  // Queue must hold two free entries before the staged byte is processed
  assign q_room    = (q_count <= CW'(QDEPTH - 2));
  assign advance   = stg_vld_r && q_room;
  assign in_tready = !stg_vld_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  // Input register
  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_xfer) stg_vld_nxt = 1'b1;
    else if (advance) stg_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) stg_vld_r <= 1'b0;
    else stg_vld_r <= stg_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  // Phase decode for the staged byte
  fjop_decode u_decode (
    .phase    (phase_r),
    .in_byte  (stg_byte_r),
    .msg_last (stg_last_r),
    .dec      (dec)
  );

  assign phase_nxt = advance ? dec.nxt : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= PH_OPEN;
    else phase_r <= phase_nxt;
  end

  // Result queue
  assign pop = out_tvalid && out_tready;

  fjop_queue #(
    .W     (RW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (advance && (dec.cnt != 2'd0)),
    .push1     (advance && (dec.cnt == 2'd2)),
    .wdata0    (dec.r0),
    .wdata1    (dec.r1),
    .pop       (pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign head       = res_t'(q_rdata);
  assign out_tvalid = q_not_empty;
  assign out_tdata  = head.ch;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

  // Checks
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QDEPTH))
    else $error("result queue overfilled");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stg_last_r |=> phase_r == PH_OPEN)
    else $error("phase not back at start after message end");

  a_two_is_error: assert property (@(posedge clk) disable iff (!rst_n)
    advance && dec.cnt == 2'd2 |-> dec.r1.kind == K_ERROR && stg_last_r)
    else $error("second result of a byte is not a message-end error");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !advance && !pop |=> $stable(q_count))
    else $error("queue count moved without transfer");

endmodule

`default_nettype wire
